// ===== sv/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Sizes, field types and request and status codes that the allocator and its
// storage share.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Number of slots and generation width.
  localparam int SlotCount = 256;
  localparam int GenW      = 16;

  // Widths that follow from the sizes above.
  localparam int IdxW = $clog2(SlotCount);
  localparam int CntW = $clog2(SlotCount + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [GenW-1:0] gen_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [1:0]      kind_t;
  typedef logic [1:0]      status_t;

  // Request codes.
  localparam kind_t KindAlloc    = 2'd0;
  localparam kind_t KindFree     = 2'd1;
  localparam kind_t KindValidate = 2'd2;

  // Result status codes.
  localparam status_t StatusOk    = 2'd0;
  localparam status_t StatusStale = 2'd1;
  localparam status_t StatusFull  = 2'd2;

endpackage

// ===== sv/gha_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data. The read data
// holds its value in cycles without a read.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; returns the old word on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/generational_handle_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out handles made of a slot index and a generation. Allocate pops the
// most recently freed slot (or takes a never-used one), free retires a
// current handle and pushes its slot, validate checks a handle.
//
//  Channel | Handshake                  | Word
//  --------+----------------------------+------------------------------------
//  request | in_valid_i / in_ready_o    | kind, slot_index, slot_generation
//  result  | out_valid_o / out_ready_i  | status, handle_index,
//          |                            | handle_generation, live_slots
//
// One request is taken every cycle while results are taken; a result passes
// through the request register, then the result register.
// The rate is set by the generation-table read-modify-write loop, closed
// through a one-entry write bypass and the two top stack entries in flops.
// Reset clears the counters and control flags only; the tables need no sweep.
// A stalled result register holds the request register, which stops intake.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gha_pkg::kind_t   kind_i,
  input  gha_pkg::idx_t    slot_index_i,
  input  gha_pkg::gen_t    slot_generation_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gha_pkg::status_t status_o,
  output gha_pkg::idx_t    handle_index_o,
  output gha_pkg::gen_t    handle_generation_o,
  output gha_pkg::cnt_t    live_slots_o
);

  import gha_pkg::*;

  localparam cnt_t SlotCnt = cnt_t'(SlotCount);

  // Request register.
  logic  s1_valid_q;
  kind_t s1_kind_q;
  idx_t  s1_idx_q;
  gen_t  s1_gen_q;

  // Allocator state.
  cnt_t free_count_q, free_count_d;
  cnt_t fresh_mark_q, fresh_mark_d;
  cnt_t live_count_q, live_count_d;
  idx_t top_q, top_d;
  idx_t sec_q, sec_d;
  logic sec_ram_q, sec_ram_d;

  // Generation table bypass.
  logic fwd_hit_q, fwd_hit_d;
  gen_t fwd_data_q;

  // Result register.
  logic    out_valid_q;
  status_t status_q;
  idx_t    handle_index_q;
  gen_t    handle_generation_q;
  cnt_t    live_slots_q;

  // Memory ports.
  logic gen_we;
  idx_t gen_waddr;
  gen_t gen_wdata;
  idx_t gen_raddr;
  gen_t gen_rdata;
  logic stk_we;
  idx_t stk_waddr;
  idx_t stk_wdata;
  logic stk_re;
  idx_t stk_raddr;
  idx_t stk_rdata;

  logic    accept;
  logic    commit;
  gen_t    cur_gen;
  idx_t    sec_eff;
  logic    current;
  cnt_t    fc_m2;
  cnt_t    fc_m3;
  status_t res_status;
  idx_t    res_idx;
  gen_t    res_gen;

  // Handshake: the result stage commits when its register is free or drained.
  assign commit     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || commit;
  assign accept     = in_valid_i && in_ready_o;

  // Current generation of the slot held in the request register.
  assign cur_gen = fwd_hit_q ? fwd_data_q : gen_rdata;
  assign sec_eff = sec_ram_q ? stk_rdata : sec_q;
  assign current = (cnt_t'(s1_idx_q) < fresh_mark_q) && (cur_gen == s1_gen_q);
  assign fc_m2   = free_count_q - cnt_t'(2);
  assign fc_m3   = free_count_q - cnt_t'(3);

  // Result stage: decide the request and update the state.
  always_comb begin
    free_count_d = free_count_q;
    fresh_mark_d = fresh_mark_q;
    live_count_d = live_count_q;
    top_d        = top_q;
    sec_d        = sec_q;
    sec_ram_d    = sec_ram_q;
    gen_we       = 1'b0;
    gen_waddr    = s1_idx_q;
    gen_wdata    = cur_gen + gen_t'(1);
    stk_we       = 1'b0;
    stk_waddr    = fc_m2[IdxW-1:0];
    stk_wdata    = sec_eff;
    stk_re       = 1'b0;
    stk_raddr    = fc_m3[IdxW-1:0];
    res_status   = StatusOk;
    res_idx      = '0;
    res_gen      = '0;
    if (commit) begin
      sec_d     = sec_eff;
      sec_ram_d = 1'b0;
      case (s1_kind_q)
        KindAlloc: begin
          if (free_count_q != '0) begin
            // Pop the most recently freed slot and bump its generation.
            gen_we       = 1'b1;
            gen_waddr    = top_q;
            res_idx      = top_q;
            res_gen      = cur_gen + gen_t'(1);
            top_d        = sec_eff;
            free_count_d = free_count_q - cnt_t'(1);
            if (free_count_q >= cnt_t'(3)) begin
              stk_re    = 1'b1;
              sec_ram_d = 1'b1;
            end
            if (live_count_q < SlotCnt) begin
              live_count_d = live_count_q + cnt_t'(1);
            end
          end else if (fresh_mark_q != SlotCnt) begin
            // Take the next never-used slot at generation one.
            gen_we       = 1'b1;
            gen_waddr    = fresh_mark_q[IdxW-1:0];
            gen_wdata    = gen_t'(1);
            res_idx      = fresh_mark_q[IdxW-1:0];
            res_gen      = gen_t'(1);
            fresh_mark_d = fresh_mark_q + cnt_t'(1);
            if (live_count_q < SlotCnt) begin
              live_count_d = live_count_q + cnt_t'(1);
            end
          end else begin
            res_status = StatusFull;
          end
        end
        KindFree: begin
          if (current) begin
            gen_we = 1'b1;
            // Push the slot; the old second entry spills to memory.
            if (free_count_q < SlotCnt) begin
              top_d        = s1_idx_q;
              sec_d        = top_q;
              stk_we       = (free_count_q >= cnt_t'(2));
              free_count_d = free_count_q + cnt_t'(1);
            end
            if (live_count_q != '0) begin
              live_count_d = live_count_q - cnt_t'(1);
            end
          end else begin
            res_status = StatusStale;
          end
        end
        KindValidate: begin
          if (!current) begin
            res_status = StatusStale;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request stage: read the generation of the slot this request will touch,
  // using the state as it stands after the commit in this cycle.
  always_comb begin
    if (kind_i == KindAlloc) begin
      gen_raddr = (free_count_d != '0) ? top_d : fresh_mark_d[IdxW-1:0];
    end else begin
      gen_raddr = slot_index_i;
    end
    fwd_hit_d = gen_we && (gen_waddr == gen_raddr);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      free_count_q <= '0;
      fresh_mark_q <= '0;
      live_count_q <= '0;
      sec_ram_q    <= 1'b0;
      fwd_hit_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
        fwd_hit_q  <= in_valid_i && fwd_hit_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      free_count_q <= free_count_d;
      fresh_mark_q <= fresh_mark_d;
      live_count_q <= live_count_d;
      sec_ram_q    <= sec_ram_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
    if (accept) begin
      s1_kind_q  <= kind_i;
      s1_idx_q   <= slot_index_i;
      s1_gen_q   <= slot_generation_i;
      fwd_data_q <= gen_wdata;
    end
    if (commit) begin
      status_q            <= res_status;
      handle_index_q      <= res_idx;
      handle_generation_q <= res_gen;
      live_slots_q        <= live_count_d;
    end
  end

  // Generation of each slot.
  gha_ram #(
    .Width (GenW),
    .Depth (SlotCount)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (accept),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  // Free stack below the two entries kept in flops.
  gha_ram #(
    .Width (IdxW),
    .Depth (SlotCount)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign handle_index_o      = handle_index_q;
  assign handle_generation_o = handle_generation_q;
  assign live_slots_o        = live_slots_q;

  // The live count saturates at the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_count_q <= SlotCnt)
    else $error("live count above slot count");

  // Counters stay within the slot range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_count_q <= SlotCnt) && (fresh_mark_q <= SlotCnt))
    else $error("stack or high-water count out of range");

  // A second entry in flight from memory needs at least two stacked slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_ram_q |-> (free_count_q >= cnt_t'(2)))
    else $error("stack refill with too few entries");

  // A bypass hit only exists for a request that is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("bypass hit without a request");

  // Every commit leaves a word in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed word lost");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives allocate, free and validate words into the allocator and checks
// every result word against a behavioral allocator kept in the testbench.
// The stimulus is planned up front on a second copy of that allocator, so
// frees and validates can target live, retired and forged handles. The
// run covers a fill-to-full and drain pass.
// ----------------------------------------------------------------------------
module tb_top;
  import gha_pkg::*;

  // Copies of the behavioral allocator: one plans stimulus, one checks.
  localparam int PlanCopy  = 0;
  localparam int CheckCopy = 1;

  typedef struct {
    kind_t kind;
    idx_t  idx;
    gen_t  gen;
    int    phase;
  } request_t;

  typedef struct {
    status_t status;
    idx_t    idx;
    gen_t    gen;
    cnt_t    live;
  } answer_t;

  typedef struct packed {
    idx_t idx;
    gen_t gen;
  } handle_t;

  // Clock, reset and the signals driven into the allocator.
  logic    clk_i     = 1'b0;
  logic    rst_ni    = 1'b0;
  logic    req_valid = 1'b0;
  kind_t   req_kind  = KindAlloc;
  idx_t    req_index = '0;
  gen_t    req_gen   = '0;
  logic    res_ready = 1'b0;
  logic    in_ready_o;
  logic    out_valid_o;
  status_t status_o;
  idx_t    handle_index_o;
  gen_t    handle_generation_o;
  cnt_t    live_slots_o;

  // Behavioral allocator state, one set per copy.
  gen_t shadow_gen   [2][SlotCount];
  idx_t shadow_stack [2][SlotCount];
  int   shadow_depth [2] = '{0, 0};
  int   shadow_fresh [2] = '{0, 0};
  int   shadow_live  [2] = '{0, 0};

  // Stimulus plan and bookkeeping.
  request_t pending_requests [$];
  answer_t  pending_results  [$];
  handle_t  live_handles     [$];
  handle_t  retired_handles  [$];
  int       fill_phase    = 0;
  int       traffic_phase = 0;
  int unsigned send_idle_pct  [3] = '{12, 57, 0};
  int unsigned recv_stall_pct [3] = '{57, 12, 0};

  request_t next_req;
  answer_t  predicted;
  answer_t  want;
  int       requests_taken = 0;
  int       results_seen   = 0;
  int       errors         = 0;
  int       ok_count       = 0;
  int       stale_count    = 0;
  int       full_count     = 0;

  generational_handle_allocator_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (req_valid),
    .in_ready_o          (in_ready_o),
    .kind_i              (req_kind),
    .slot_index_i        (req_index),
    .slot_generation_i   (req_gen),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (res_ready),
    .status_o            (status_o),
    .handle_index_o      (handle_index_o),
    .handle_generation_o (handle_generation_o),
    .live_slots_o        (live_slots_o)
  );

  always #10 clk_i = ~clk_i;

  // A handle is current when its slot was handed out and the generation matches.
  function automatic bit handle_is_current(int c, idx_t idx, gen_t gen);
    return (int'(idx) < shadow_fresh[c]) && (shadow_gen[c][idx] == gen);
  endfunction

  // Applies one request word to a copy of the allocator and returns its result.
  function automatic answer_t step_allocator(int c, kind_t kind, idx_t idx, gen_t gen);
    answer_t a;
    idx_t    slot;
    a = '{StatusOk, '0, '0, '0};
    case (kind)
      KindAlloc: begin
        if (shadow_depth[c] > 0) begin
          // Reuse the most recently freed slot.
          shadow_depth[c]--;
          slot = shadow_stack[c][shadow_depth[c]];
          shadow_gen[c][slot] = shadow_gen[c][slot] + gen_t'(1);
          a.idx = slot;
          a.gen = shadow_gen[c][slot];
          if (shadow_live[c] < SlotCount) shadow_live[c]++;
        end else if (shadow_fresh[c] < SlotCount) begin
          // Take a never-used slot at generation one.
          slot = idx_t'(shadow_fresh[c]);
          shadow_fresh[c]++;
          shadow_gen[c][slot] = gen_t'(1);
          a.idx = slot;
          a.gen = shadow_gen[c][slot];
          if (shadow_live[c] < SlotCount) shadow_live[c]++;
        end else begin
          a.status = StatusFull;
        end
      end
      KindFree: begin
        if (handle_is_current(c, idx, gen)) begin
          shadow_gen[c][idx] = shadow_gen[c][idx] + gen_t'(1);
          // The push is dropped when the stack is already full.
          if (shadow_depth[c] < SlotCount) begin
            shadow_stack[c][shadow_depth[c]] = idx;
            shadow_depth[c]++;
          end
          if (shadow_live[c] > 0) shadow_live[c]--;
        end else begin
          a.status = StatusStale;
        end
      end
      KindValidate: begin
        a.status = handle_is_current(c, idx, gen) ? StatusOk : StatusStale;
      end
      default: begin
      end
    endcase
    a.live = cnt_t'(shadow_live[c]);
    return a;
  endfunction

  // Queues one request word and tracks which handles it creates or retires.
  task automatic add_request(kind_t kind, idx_t idx, gen_t gen);
    answer_t  a;
    request_t r;
    handle_t  h;
    a = step_allocator(PlanCopy, kind, idx, gen);
    r = '{kind, idx, gen, fill_phase};
    pending_requests.insert(pending_requests.size(), r);
    if (kind == KindAlloc && a.status == StatusOk) begin
      h = {a.idx, a.gen};
      live_handles.insert(live_handles.size(), h);
    end
    if (kind == KindFree && a.status == StatusOk) begin
      for (int i = live_handles.size() - 1; i >= 0; i--) begin
        if (live_handles[i].idx == idx) live_handles.delete(i);
      end
      h = {idx, gen};
      retired_handles.insert(retired_handles.size(), h);
      if (retired_handles.size() > 64) void'(retired_handles.pop_front());
    end
  endtask

  // Mostly well-formed traffic with some stale, forged and random words.
  task automatic add_random_mix(int count);
    int      sel;
    int      pick;
    handle_t h;
    idx_t    slot;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 35 || (sel < 65 && live_handles.size() == 0)) begin
        add_request(KindAlloc, idx_t'($urandom), gen_t'($urandom));
      end else if (sel < 65) begin
        pick = $urandom_range(live_handles.size() - 1);
        h = live_handles[pick];
        add_request(KindFree, h.idx, h.gen);
      end else if (sel < 75 && live_handles.size() != 0) begin
        pick = $urandom_range(live_handles.size() - 1);
        h = live_handles[pick];
        add_request(KindValidate, h.idx, h.gen);
      end else if (sel < 85 && retired_handles.size() != 0) begin
        pick = $urandom_range(retired_handles.size() - 1);
        h = retired_handles[pick];
        add_request($urandom_range(1) ? KindFree : KindValidate, h.idx, h.gen);
      end else if (sel < 90 && shadow_fresh[PlanCopy] > 0) begin
        // Free a slot by its table generation, issued or not.
        slot = idx_t'($urandom_range(shadow_fresh[PlanCopy] - 1));
        add_request(KindFree, slot, shadow_gen[PlanCopy][slot]);
      end else begin
        add_request(kind_t'($urandom_range(3)), idx_t'($urandom), gen_t'($urandom));
      end
    end
  endtask

  // Allocates every slot, runs into the full case, then frees everything.
  task automatic add_fill_and_drain();
    int      pick;
    handle_t h;
    while (!(shadow_depth[PlanCopy] == 0 && shadow_fresh[PlanCopy] == SlotCount)) begin
      add_request(KindAlloc, '0, '0);
    end
    repeat (3) add_request(KindAlloc, idx_t'($urandom), gen_t'($urandom));
    while (live_handles.size() != 0) begin
      pick = $urandom_range(live_handles.size() - 1);
      h = live_handles[pick];
      live_handles.delete(pick);
      add_request(KindFree, h.idx, h.gen);
    end
    // With the stack full these pushes are dropped and the live count stays at zero.
    repeat (2) add_request(KindFree, 8'd7, shadow_gen[PlanCopy][7]);
  endtask

  // Request driver: presents planned words and predicts each accepted one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && in_ready_o) begin
        predicted = step_allocator(CheckCopy, req_kind, req_index, req_gen);
        pending_results.insert(pending_results.size(), predicted);
        requests_taken++;
      end
      if (!req_valid || in_ready_o) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(99) >= send_idle_pct[pending_requests[0].phase]) begin
          next_req = pending_requests.pop_front();
          req_kind      <= next_req.kind;
          req_index     <= next_req.idx;
          req_gen       <= next_req.gen;
          traffic_phase <= next_req.phase;
          req_valid     <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct[traffic_phase]);
    end
  end

  task automatic compare_field(string field, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, field, exp_val, act_val);
    end
  endtask

  // Result monitor: each accepted word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && res_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual status %0d index %0d",
                 $time, status_o, handle_index_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, status_o);
        compare_field("handle_index", want.idx, handle_index_o);
        compare_field("handle_generation", want.gen, handle_generation_o);
        compare_field("live_slots", want.live, live_slots_o);
        case (want.status)
          StatusOk:    ok_count++;
          StatusStale: stale_count++;
          StatusFull:  full_count++;
          default: begin
          end
        endcase
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    // Directed words: empty allocator, first slots, stale, forged and unused kind.
    fill_phase = 0;
    add_request(KindValidate, 8'd0, 16'd0);
    add_request(KindFree, 8'd0, 16'd0);
    add_request(kind_t'(2'd3), 8'hFF, 16'hFFFF);
    add_request(KindAlloc, 8'hFF, 16'hFFFF);
    add_request(KindAlloc, '0, '0);
    add_request(KindAlloc, '0, '0);
    add_request(KindValidate, 8'd1, 16'd1);
    add_request(KindValidate, 8'd1, 16'd2);
    add_request(KindValidate, 8'hFF, 16'hFFFF);
    add_request(KindFree, 8'd1, 16'd1);
    add_request(KindFree, 8'd1, 16'd1);
    add_request(KindFree, 8'd1, 16'd2);
    add_request(KindAlloc, '0, '0);
    add_request(KindAlloc, '0, '0);
    add_request(KindFree, 8'd0, 16'd1);
    add_request(KindFree, 8'd2, 16'd1);
    add_request(KindFree, 8'd1, 16'd4);
    add_request(KindFree, 8'd0, 16'd2);
    add_request(KindValidate, 8'd0, 16'd3);
    add_request(KindAlloc, '0, '0);

    // Random traffic in three idling phases, with a fill pass in the middle.
    add_random_mix(320);
    fill_phase = 1;
    add_random_mix(100);
    add_fill_and_drain();
    add_random_mix(100);
    fill_phase = 2;
    add_random_mix(230);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || req_valid) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d result words for %0d requests across three idling phases.",
             results_seen, requests_taken);
    $display("Answers: %0d ok, %0d stale, %0d full; includes a fill-to-full pass.",
             ok_count, stale_count, full_count);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gha_pkg.sv
sv/gha_ram.sv
sv/generational_handle_allocator_unit.sv
tb/sv/tb_top.sv
